/* design/imt_pkg.sv */
`default_nettype none
package imt_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_TAKE   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REVERSED = 2'd2;

  localparam int HELD_W = 5;

  // Commands broadcast to every cell of the chain.
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_MERGE = 3'd1;
  localparam logic [2:0] OP_SHL   = 3'd2;
  localparam logic [2:0] OP_SHR   = 3'd3;
  localparam logic [2:0] OP_ROT   = 3'd4;
  localparam logic [2:0] OP_CLR   = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       keep;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* design/imt_cell.sv */
`default_nettype none
module imt_cell
  import imt_pkg::*;
#(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire             clk,
  input  wire             rst_n,
  input  cell_cmd_t       cmd,
  input  wire  [IW-1:0]   pos,
  input  wire  [63:0]     key_b,
  input  wire  [63:0]     key_e,
  input  wire             prev_ovl,
  input  wire             next_ovl,
  input  wire  [63:0]     rgt_lo,
  input  wire  [63:0]     rgt_hi,
  input  wire             rgt_valid,
  input  wire  [63:0]     lft_lo,
  input  wire  [63:0]     lft_hi,
  input  wire             lft_valid,
  output logic [63:0]     lo,
  output logic [63:0]     hi,
  output logic            valid,
  output logic            left_flag,
  output logic            ovl_flag,
  output logic            below_flag
);

  logic [63:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic        valid_r, valid_nxt;
  logic        right_flag, at_pos, past_pos;

  assign lo    = lo_r;
  assign hi    = hi_r;
  assign valid = valid_r;

  // Adjacent intervals count as touching; the compares are done one bit wider
  // so that the plus one never wraps.
  assign left_flag  = valid_r && (({1'b0, hi_r} + 65'd1) < {1'b0, key_b});
  assign right_flag = {1'b0, lo_r} > ({1'b0, key_e} + 65'd1);
  assign ovl_flag   = valid_r && !left_flag && !right_flag;
  assign below_flag = valid_r && (hi_r < key_b);

  assign at_pos   = (pos == IW'(IDX));
  assign past_pos = (IW'(IDX) > pos);

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    valid_nxt = valid_r;
    case (cmd.op)
      OP_MERGE: begin
        if (ovl_flag && !prev_ovl && key_b < lo_r) lo_nxt = key_b;
        if (ovl_flag && !next_ovl && key_e > hi_r) hi_nxt = key_e;
      end
      OP_SHL: begin
        if (past_pos || (at_pos && !cmd.keep)) begin
          lo_nxt    = rgt_lo;
          hi_nxt    = rgt_hi;
          valid_nxt = rgt_valid;
        end else if (at_pos) begin
          // The merged interval keeps its start and takes the end of the
          // next absorbed interval.
          hi_nxt    = rgt_hi;
          valid_nxt = rgt_valid;
        end
      end
      OP_SHR: begin
        if (past_pos) begin
          lo_nxt    = lft_lo;
          hi_nxt    = lft_hi;
          valid_nxt = lft_valid;
        end else if (at_pos) begin
          lo_nxt    = key_b;
          hi_nxt    = key_e;
          valid_nxt = 1'b1;
        end
      end
      OP_ROT: begin
        lo_nxt    = rgt_lo;
        hi_nxt    = rgt_hi;
        valid_nxt = rgt_valid;
      end
      OP_CLR:  valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/interval_merge_table_unit.sv */
// Channel  | Handshake              | Payload
// input    | start, busy            | in_action, in_range_begin, in_range_end
// result   | out_valid (one cycle)  | out_hit, out_found_end, out_status,
//          |                        | out_intervals_held, out_indexes_held
//
// An insert or take is a walk along the row of cells: an evaluation step, one
// shift per interval absorbed or discarded, and a full rotation of the row
// that sums the held indexes at cell zero. A clear or a reversed insert goes
// straight to the rotation.
// Reset empties the table at once. The result strobe cannot be held off.
`default_nettype none
module interval_merge_table_unit
  import imt_pkg::*;
#(
  parameter int MAX_INTERVALS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_action,
  input  wire  [63:0] in_range_begin,
  input  wire  [63:0] in_range_end,
  output logic        out_valid,
  output logic        out_hit,
  output logic [63:0] out_found_end,
  output logic [1:0]  out_status,
  output logic [4:0]  out_intervals_held,
  output logic [63:0] out_indexes_held
);

  localparam int N  = MAX_INTERVALS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_TAKE  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;

  logic [2:0]    state_r, state_nxt, after_r, after_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, occ_r, occ_nxt;
  logic [IW-1:0] pos_r, pos_nxt, cell_pos;
  logic          keep_r, keep_nxt;
  logic [63:0]   b_r, b_nxt, e_r, e_nxt;
  logic [63:0]   sum_r, sum_nxt;
  logic          hit_r, hit_nxt;
  logic [63:0]   found_r, found_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [63:0]   oidx_r, oidx_nxt;
  cell_cmd_t     cmd;

  logic [63:0] lo_w [N];
  logic [63:0] hi_w [N];
  logic [N-1:0] valid_w, left_w, ovl_w, below_w;

  logic [CW-1:0] n_left, n_ovl, n_below;
  logic [63:0]   span;
  logic [64:0]   add, acc;
  logic          accept;
  logic [CW+HELD_W-1:0] occ_ext;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [63:0] r_lo, r_hi, l_lo, l_hi;
    logic        r_valid, l_valid, p_ovl, n_ovl_s;
    if (i == N - 1) begin : g_last
      // The last cell closes the ring only while the row rotates.
      assign r_lo    = lo_w[0];
      assign r_hi    = hi_w[0];
      assign r_valid = (cmd.op == OP_ROT) && valid_w[0];
      assign n_ovl_s = 1'b0;
    end else begin : g_mid
      assign r_lo    = lo_w[i+1];
      assign r_hi    = hi_w[i+1];
      assign r_valid = valid_w[i+1];
      assign n_ovl_s = ovl_w[i+1];
    end
    if (i == 0) begin : g_first
      assign l_lo    = 64'd0;
      assign l_hi    = 64'd0;
      assign l_valid = 1'b0;
      assign p_ovl   = 1'b0;
    end else begin : g_rest
      assign l_lo    = lo_w[i-1];
      assign l_hi    = hi_w[i-1];
      assign l_valid = valid_w[i-1];
      assign p_ovl   = ovl_w[i-1];
    end
    imt_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd), .pos(cell_pos),
      .key_b(b_r), .key_e(e_r), .prev_ovl(p_ovl), .next_ovl(n_ovl_s),
      .rgt_lo(r_lo), .rgt_hi(r_hi), .rgt_valid(r_valid),
      .lft_lo(l_lo), .lft_hi(l_hi), .lft_valid(l_valid),
      .lo(lo_w[i]), .hi(hi_w[i]), .valid(valid_w[i]),
      .left_flag(left_w[i]), .ovl_flag(ovl_w[i]), .below_flag(below_w[i])
    );
  end

  always_comb begin
    n_left  = '0;
    n_ovl   = '0;
    n_below = '0;
    for (int i = 0; i < N; i++) begin
      n_left  = n_left + CW'(left_w[i]);
      n_ovl   = n_ovl + CW'(ovl_w[i]);
      n_below = n_below + CW'(below_w[i]);
    end
  end

  assign span = hi_w[0] - lo_w[0];
  assign add  = {1'b0, span} + 65'd1;
  assign acc  = {1'b0, sum_r} + (valid_w[0] ? add : 65'd0);

  always_comb begin
    state_nxt  = state_r;
    after_nxt  = after_r;
    cnt_nxt    = cnt_r;
    occ_nxt    = occ_r;
    pos_nxt    = pos_r;
    keep_nxt   = keep_r;
    b_nxt      = b_r;
    e_nxt      = e_r;
    sum_nxt    = sum_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    oidx_nxt   = oidx_r;
    ovalid_nxt = 1'b0;
    cmd.op     = OP_HOLD;
    cmd.keep   = 1'b0;
    cell_pos   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          b_nxt      = in_range_begin;
          e_nxt      = in_range_end;
          hit_nxt    = 1'b0;
          found_nxt  = 64'd0;
          status_nxt = ST_OK;
          cnt_nxt    = CW'(N);
          sum_nxt    = 64'd0;
          state_nxt  = S_SUM;
          case (in_action)
            ACT_INSERT: begin
              if (in_range_begin > in_range_end) status_nxt = ST_REVERSED;
              else state_nxt = S_INS;
            end
            ACT_TAKE: state_nxt = S_TAKE;
            ACT_CLEAR: begin
              cmd.op  = OP_CLR;
              occ_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        cnt_nxt   = CW'(N);
        sum_nxt   = 64'd0;
        state_nxt = S_SUM;
        if (n_ovl == '0) begin
          if (occ_r == CW'(N)) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.op   = OP_SHR;
            cell_pos = n_left[IW-1:0];
            occ_nxt  = occ_r + CW'(1);
          end
        end else begin
          cmd.op  = OP_MERGE;
          pos_nxt = n_left[IW-1:0];
          occ_nxt = occ_r - (n_ovl - CW'(1));
          if (n_ovl != CW'(1)) begin
            keep_nxt  = 1'b1;
            cnt_nxt   = n_ovl - CW'(1);
            after_nxt = S_SUM;
            state_nxt = S_SHIFT;
          end
        end
      end
      S_TAKE: begin
        occ_nxt   = occ_r - n_below;
        state_nxt = S_CHECK;
        if (n_below != '0) begin
          pos_nxt   = '0;
          keep_nxt  = 1'b0;
          cnt_nxt   = n_below;
          after_nxt = S_CHECK;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.op   = OP_SHL;
        cmd.keep = keep_r;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = CW'(N);
          sum_nxt   = 64'd0;
          state_nxt = after_r;
        end
      end
      S_CHECK: begin
        cnt_nxt   = CW'(N);
        sum_nxt   = 64'd0;
        state_nxt = S_SUM;
        if (valid_w[0] && lo_w[0] <= b_r) begin
          hit_nxt   = 1'b1;
          found_nxt = hi_w[0];
          cmd.op    = OP_SHL;
          cell_pos  = '0;
          occ_nxt   = occ_r - CW'(1);
        end
      end
      S_SUM: begin
        cmd.op  = OP_ROT;
        sum_nxt = acc[64] ? {64{1'b1}} : acc[63:0];
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          oidx_nxt   = sum_nxt;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    after_r  <= after_nxt;
    cnt_r    <= cnt_nxt;
    pos_r    <= pos_nxt;
    keep_r   <= keep_nxt;
    b_r      <= b_nxt;
    e_r      <= e_nxt;
    sum_r    <= sum_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    oidx_r   <= oidx_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign occ_ext            = {{HELD_W{1'b0}}, occ_r};
  assign out_valid          = ovalid_r;
  assign out_hit            = hit_r;
  assign out_found_end      = found_r;
  assign out_status         = status_r;
  assign out_intervals_held = occ_ext[HELD_W-1:0];
  assign out_indexes_held   = oidx_r;

endmodule
`default_nettype wire

/* design/imt_checker.sv */
`default_nettype none
module imt_checker
  import imt_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        out_valid,
  input wire        out_hit,
  input wire [63:0] out_found_end,
  input wire [1:0]  out_status
);

  // An accepted transfer keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accepted transfer");

  // A result only ends a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_status == ST_OK) else $error("hit with error status");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_end == 64'd0) else $error("miss with end");

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

endmodule

bind interval_merge_table_unit imt_checker u_imt_checker (.*);
`default_nettype wire
